>>> rtl/sat_pkg.sv
// Shared constants for the separating-axis polygon collision block.
// No dependencies.
`default_nettype none
package sat_pkg;
	localparam int MAX_VERTICES = 16;
	localparam int CW    = 24;
	localparam int AW    = $clog2(MAX_VERTICES);
	localparam int CNTW  = $clog2(MAX_VERTICES + 1);
	localparam int VW    = 2 * CW;
	localparam int AXW   = CW + 1;
	localparam int PW    = 2 * AXW;
	localparam int RADW  = 62;
	localparam int LENW  = RADW / 2;
	localparam int DVDW  = PW + 6;
	localparam int DCW   = $clog2(DVDW);
	localparam int DEPW  = 32;
endpackage
`default_nettype wire

>>> rtl/sat_convex_polygon_collision.sv
// Separating-axis collision test for two convex polygons, held in two vertex memories.
// Depends on sat_pkg.
//
// Usage: vertices arrive on the input channel (in_valid/in_ready), one per request,
// with command selecting polygon A (0) or B (1). The request with end_of_pair set is
// stored and then starts the evaluation; no input is taken until it is finished.
// One result per pair leaves on the output channel (out_valid/out_ready) through an
// output register, so new vertices are accepted while a result waits to be taken.
// The single configuration register (compute_depth) is written over cfg_valid/
// cfg_ready with cfg_data, and is sampled when end_of_pair is accepted.
// Throughput: one vertex per cycle while loading. Evaluation begins with a start step,
// then for every edge of A then of B reads the edge ends and forms the axis, and for
// each vertex of both polygons does one memory read, one multiply, one add-and-compare;
// a zero-length edge is skipped without projection. In depth mode each tested edge also
// squares its axis and runs the 31-step square root and 56-step divider. A separating
// edge ends the walk early.
// A result that is not taken holds the block after evaluation until out_ready.
// Reset clears counts, overflow flag and output flags and sets depth to all ones; the
// vertex memories are not cleared: only entries written since the last pair are read.
`default_nettype none
module sat_convex_polygon_collision
	import sat_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic                  cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  command,
	input  wire logic signed [CW-1:0]  vertex_x,
	input  wire logic signed [CW-1:0]  vertex_y,
	input  wire logic                  end_of_pair,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       collided,
	output logic [DEPW-1:0]            depth,
	output logic                       too_many_vertices
);
	typedef enum logic [4:0] {
		ST_IDLE, ST_START, ST_EDGE_RD0, ST_EDGE_RD1, ST_EDGE_AX, ST_EDGE_CHK,
		ST_PRJ_RD, ST_PRJ_MUL, ST_PRJ_UPD, ST_CMP, ST_SQ_MUL, ST_SQ_ADD,
		ST_SQRT, ST_DIV, ST_DEPTH_UPD, ST_FINISH
	} state_t;

	state_t state_q;
	logic [VW-1:0] mem_a [MAX_VERTICES];
	logic [VW-1:0] mem_b [MAX_VERTICES];
	logic [VW-1:0] rdata_a_q, rdata_b_q;
	logic [CNTW-1:0] count_a_q, count_b_q;
	logic ovf_q, compute_depth_q, deep_q, hit_q, pass_q, side_q;
	logic [AW-1:0] edge_q, k_q;
	logic signed [CW-1:0] pi_x_q, pi_y_q;
	logic signed [AXW-1:0] ax_q, ay_q;
	logic signed [PW-1:0] prod0_q, prod1_q, lo_p_q, hi_p_q, lo_q_q, hi_q_q;
	logic [PW-1:0] ov_q;
	logic [RADW-1:0] rad_q, root_q, bit_q;
	logic [LENW-1:0] rem_q;
	logic [DVDW-1:0] dvd_q, quo_q;
	logic [DCW-1:0] dcnt_q;
	logic [DEPW-1:0] best_q;

	logic rd_sel;
	logic [AW-1:0] rd_addr, edge_next;
	logic [CNTW-1:0] n_p, n_q, n_cur;
	logic signed [CW-1:0] rd_x, rd_y;
	logic signed [AXW-1:0] op0a, op0b, op1a, op1b;
	logic signed [PW-1:0] psum, top, bot;
	logic [RADW-1:0] trial;
	logic [LENW:0] rem_sh, len_ext;
	logic [DEPW-1:0] dval;
	logic edge_last, in_acc;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;

	assign n_p   = pass_q ? count_b_q : count_a_q;
	assign n_q   = pass_q ? count_a_q : count_b_q;
	assign n_cur = side_q ? n_q : n_p;
	assign edge_last = ({1'b0, edge_q} + 1'b1) == n_p;
	assign edge_next = edge_last ? '0 : edge_q + 1'b1;

	always_comb begin
		rd_sel  = pass_q;
		rd_addr = edge_q;
		unique case (state_q)
			ST_EDGE_RD1: rd_addr = edge_next;
			ST_PRJ_RD, ST_PRJ_MUL, ST_PRJ_UPD: begin
				rd_sel  = pass_q ^ side_q;
				rd_addr = k_q;
			end
			default: rd_addr = edge_q;
		endcase
	end

	assign rd_x = rd_sel ? rdata_b_q[VW-1:CW] : rdata_a_q[VW-1:CW];
	assign rd_y = rd_sel ? rdata_b_q[CW-1:0]  : rdata_a_q[CW-1:0];

	always_comb begin
		if (state_q == ST_SQ_MUL) begin
			op0a = ax_q;
			op0b = ax_q;
			op1a = ay_q;
			op1b = ay_q;
		end else begin
			op0a = AXW'(rd_x);
			op0b = ax_q;
			op1a = AXW'(rd_y);
			op1b = ay_q;
		end
	end

	assign psum    = prod0_q + prod1_q;
	assign top     = (hi_p_q < hi_q_q) ? hi_p_q : hi_q_q;
	assign bot     = (lo_p_q > lo_q_q) ? lo_p_q : lo_q_q;
	assign trial   = root_q + bit_q;
	assign rem_sh  = {rem_q, dvd_q[DVDW-1]};
	assign len_ext = {1'b0, root_q[LENW-1:0]};
	assign dval    = (quo_q[DVDW-1:DEPW] != '0) ? '1 : quo_q[DEPW-1:0];

	always_ff @(posedge clk) begin
		if (in_acc && !command && count_a_q < CNTW'(MAX_VERTICES))
			mem_a[count_a_q[AW-1:0]] <= {vertex_x, vertex_y};
		if (in_acc && command && count_b_q < CNTW'(MAX_VERTICES))
			mem_b[count_b_q[AW-1:0]] <= {vertex_x, vertex_y};
		rdata_a_q <= mem_a[rd_addr];
		rdata_b_q <= mem_b[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			count_a_q         <= '0;
			count_b_q         <= '0;
			ovf_q             <= 1'b0;
			compute_depth_q   <= 1'b1;
			out_valid         <= 1'b0;
			collided          <= 1'b0;
			depth             <= '1;
			too_many_vertices <= 1'b0;
		end else begin
			if (cfg_valid)
				compute_depth_q <= cfg_data;
			if (out_valid && out_ready && state_q != ST_FINISH)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (!command) begin
							if (count_a_q < CNTW'(MAX_VERTICES))
								count_a_q <= count_a_q + 1'b1;
							else
								ovf_q <= 1'b1;
						end else begin
							if (count_b_q < CNTW'(MAX_VERTICES))
								count_b_q <= count_b_q + 1'b1;
							else
								ovf_q <= 1'b1;
						end
						if (end_of_pair) begin
							deep_q  <= compute_depth_q;
							best_q  <= '1;
							state_q <= ST_START;
						end
					end
				end
				ST_START: begin
					pass_q <= 1'b0;
					edge_q <= '0;
					if (count_a_q == '0 || count_b_q == '0) begin
						hit_q   <= 1'b0;
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_EDGE_RD0;
					end
				end
				ST_EDGE_RD0: state_q <= ST_EDGE_RD1;
				ST_EDGE_RD1: begin
					pi_x_q  <= rd_x;
					pi_y_q  <= rd_y;
					state_q <= ST_EDGE_AX;
				end
				ST_EDGE_AX: begin
					ax_q    <= AXW'(pi_y_q) - AXW'(rd_y);
					ay_q    <= AXW'(rd_x) - AXW'(pi_x_q);
					state_q <= ST_EDGE_CHK;
				end
				ST_EDGE_CHK: begin
					side_q <= 1'b0;
					k_q    <= '0;
					if (ax_q == '0 && ay_q == '0) begin
						if (edge_last) begin
							if (pass_q) begin
								hit_q   <= 1'b1;
								state_q <= ST_FINISH;
							end else begin
								pass_q  <= 1'b1;
								edge_q  <= '0;
								state_q <= ST_EDGE_RD0;
							end
						end else begin
							edge_q  <= edge_next;
							state_q <= ST_EDGE_RD0;
						end
					end else begin
						state_q <= ST_PRJ_RD;
					end
				end
				ST_PRJ_RD: state_q <= ST_PRJ_MUL;
				ST_PRJ_MUL: begin
					prod0_q <= op0a * op0b;
					prod1_q <= op1a * op1b;
					state_q <= ST_PRJ_UPD;
				end
				ST_PRJ_UPD: begin
					if (!side_q) begin
						if (k_q == '0 || psum < lo_p_q) lo_p_q <= psum;
						if (k_q == '0 || psum > hi_p_q) hi_p_q <= psum;
					end else begin
						if (k_q == '0 || psum < lo_q_q) lo_q_q <= psum;
						if (k_q == '0 || psum > hi_q_q) hi_q_q <= psum;
					end
					if (({1'b0, k_q} + 1'b1) == n_cur) begin
						k_q <= '0;
						if (!side_q) begin
							side_q  <= 1'b1;
							state_q <= ST_PRJ_RD;
						end else begin
							state_q <= ST_CMP;
						end
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_PRJ_RD;
					end
				end
				ST_CMP: begin
					if (hi_q_q < lo_p_q || hi_p_q < lo_q_q) begin
						hit_q   <= 1'b0;
						state_q <= ST_FINISH;
					end else if (deep_q) begin
						ov_q    <= PW'(top - bot);
						state_q <= ST_SQ_MUL;
					end else begin
						state_q <= ST_DEPTH_UPD;
					end
				end
				ST_SQ_MUL: begin
					prod0_q <= op0a * op0b;
					prod1_q <= op1a * op1b;
					state_q <= ST_SQ_ADD;
				end
				ST_SQ_ADD: begin
					rad_q   <= {psum, 12'b0};
					root_q  <= '0;
					bit_q   <= RADW'(1) << (RADW - 2);
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (rad_q >= trial) begin
						rad_q  <= rad_q - trial;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						rem_q   <= '0;
						dvd_q   <= {ov_q, 6'b0};
						quo_q   <= '0;
						dcnt_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (rem_sh >= len_ext) begin
						rem_q <= LENW'(rem_sh - len_ext);
						quo_q <= {quo_q[DVDW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh[LENW-1:0];
						quo_q <= {quo_q[DVDW-2:0], 1'b0};
					end
					dvd_q  <= dvd_q << 1;
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DCW'(DVDW - 1))
						state_q <= ST_DEPTH_UPD;
				end
				ST_DEPTH_UPD: begin
					if (deep_q && dval < best_q)
						best_q <= dval;
					if (edge_last) begin
						if (pass_q) begin
							hit_q   <= 1'b1;
							state_q <= ST_FINISH;
						end else begin
							pass_q  <= 1'b1;
							edge_q  <= '0;
							state_q <= ST_EDGE_RD0;
						end
					end else begin
						edge_q  <= edge_next;
						state_q <= ST_EDGE_RD0;
					end
				end
				ST_FINISH: begin
					if (!out_valid || out_ready) begin
						out_valid         <= 1'b1;
						collided          <= hit_q;
						depth             <= (hit_q && deep_q) ? best_q : '1;
						too_many_vertices <= ovf_q;
						count_a_q         <= '0;
						count_b_q         <= '0;
						ovf_q             <= 1'b0;
						state_q           <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_hit_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !collided |-> depth == '1)
		else $error("depth set on a result without collision");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_a_q <= CNTW'(MAX_VERTICES) && count_b_q <= CNTW'(MAX_VERTICES))
		else $error("vertex count beyond store depth");
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> root_q[LENW-1:0] != '0)
		else $error("division by zero axis length");
	a_busy_no_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && end_of_pair |=> !in_ready)
		else $error("input taken during evaluation");
endmodule
`default_nettype wire
